@@ rtl/core/osil_pkg.sv @@
package osil_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_BITS = 31;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int GROUP    = 8;
  localparam int NGROUP   = (CAPACITY + GROUP - 1) / GROUP;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [CNT_W-1:0]    count_t;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2,
    ST_ANSWERED  = 2'd3
  } status_t;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_QUERY  = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_RED1,
    S_RED2
  } state_t;

  typedef struct packed {
    logic cmp;
    logic shift;
    key_t probe;
  } osil_ctl_t;

endpackage

@@ rtl/core/osil_if.sv @@
interface osil_in_if;
  import osil_pkg::*;

  logic  valid;
  logic  ready;
  mode_t mode;
  key_t  key;

  modport source (output valid, output mode, output key, input ready);
  modport sink (input valid, input mode, input key, output ready);
endinterface

interface osil_out_if;
  import osil_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  logic    found;
  key_t    bound_key;

  modport source (output valid, output status, output found, output bound_key, input ready);
  modport sink (input valid, input status, input found, input bound_key, output ready);
endinterface

@@ rtl/core/osil_cell.sv @@
module osil_cell (
  input  logic               clk,
  input  osil_pkg::osil_ctl_t ctl,
  input  logic               vld,
  input  osil_pkg::key_t     prev_key,
  input  logic               prev_a,
  output osil_pkg::key_t     key_r,
  output logic               ge_r,
  output logic               a_r,
  output logic               eq_r
);
  import osil_pkg::*;

  key_t key_nxt;
  logic ge_nxt;
  logic a_nxt;
  logic eq_nxt;

  always_comb begin
    ge_nxt  = ge_r;
    a_nxt   = a_r;
    eq_nxt  = eq_r;
    key_nxt = key_r;
    if (ctl.cmp) begin
      ge_nxt = vld && (key_r >= ctl.probe);
      a_nxt  = !vld || (key_r >= ctl.probe);
      eq_nxt = vld && (key_r == ctl.probe);
    end
    if (ctl.shift) begin
      if (prev_a) begin
        key_nxt = prev_key;
      end else if (a_r) begin
        key_nxt = ctl.probe;
      end
    end
  end

  always_ff @(posedge clk) begin
    ge_r  <= ge_nxt;
    a_r   <= a_nxt;
    eq_r  <= eq_nxt;
    key_r <= key_nxt;
  end

endmodule

@@ rtl/core/osil_reduce.sv @@
module osil_reduce (
  input  logic                          clk,
  input  logic                          en,
  input  logic [osil_pkg::CAPACITY-1:0] hit,
  input  logic [osil_pkg::CAPACITY-1:0] eq,
  input  osil_pkg::key_t                keys [osil_pkg::CAPACITY],
  output osil_pkg::key_t                bound,
  output logic                          any_hit,
  output logic                          any_eq
);
  import osil_pkg::*;

  key_t              grp_key_r [NGROUP];
  key_t              grp_key_nxt [NGROUP];
  logic [NGROUP-1:0] grp_hit_r;
  logic [NGROUP-1:0] grp_hit_nxt;
  logic [NGROUP-1:0] grp_eq_r;
  logic [NGROUP-1:0] grp_eq_nxt;

  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      grp_key_nxt[g] = '0;
      grp_hit_nxt[g] = 1'b0;
      grp_eq_nxt[g]  = 1'b0;
      for (int j = 0; j < GROUP; j++) begin
        if (g * GROUP + j < CAPACITY) begin
          grp_key_nxt[g] = grp_key_nxt[g] | (keys[g * GROUP + j] & {KEY_BITS{hit[g * GROUP + j]}});
          grp_hit_nxt[g] = grp_hit_nxt[g] | hit[g * GROUP + j];
          grp_eq_nxt[g]  = grp_eq_nxt[g] | eq[g * GROUP + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grp_key_r <= grp_key_nxt;
      grp_hit_r <= grp_hit_nxt;
      grp_eq_r  <= grp_eq_nxt;
    end
  end

  always_comb begin
    bound = '0;
    for (int g = 0; g < NGROUP; g++) begin
      bound = bound | grp_key_r[g];
    end
    any_hit = |grp_hit_r;
    any_eq  = |grp_eq_r;
  end

endmodule

@@ rtl/core/ordered_set_insert_lower_bound.sv @@
// Ordered set of keys with insert and lower-bound query.
// in_word carries mode and key; out_word returns status, found and bound_key,
// one result word for each input word, in order. Both use valid/ready.
// The keys sit in a row of CAPACITY cells in ascending order. Each word goes
// through these steps in order: accept, a compare in every cell against the key,
// a registered first-level OR over groups of cells, then a second-level OR that
// yields the answer and, for an insert, shifts the cells at and above the
// insertion point one place up the row. The next word is accepted, at the
// earliest, in the cycle after the result is loaded, so no new word is taken
// until the current one has finished the compare and the two-level reduction.
// A full store drops a new key and reports it; a duplicate is reported and
// leaves the store unchanged.
// Reset (synchronous, active low) empties the set and clears the result valid
// flag; the result fields and the cell contents are not cleared. When out_word
// stalls, the result is held and a finished item waits in its last step until
// the output register frees.
module ordered_set_insert_lower_bound (
  input logic        clk,
  input logic        rst_n,
  osil_in_if.sink    in_word,
  osil_out_if.source out_word
);
  import osil_pkg::*;

  state_t    state_r;
  state_t    state_nxt;
  count_t    count_r;
  count_t    count_nxt;
  key_t      probe_r;
  mode_t     mode_r;
  logic      out_valid_r;
  logic      out_valid_nxt;
  status_t   status_r;
  logic      found_r;
  key_t      bound_r;
  status_t   status_nxt;

  osil_ctl_t ctl;
  logic      accept;
  logic      out_load;
  logic      red_en;
  logic      full;
  logic      do_insert;

  key_t                cell_key [CAPACITY];
  key_t                prev_key [CAPACITY];
  logic [CAPACITY-1:0] cell_ge;
  logic [CAPACITY-1:0] cell_a;
  logic [CAPACITY-1:0] cell_eq;
  logic [CAPACITY-1:0] cell_vld;
  logic [CAPACITY-1:0] prev_ge;
  logic [CAPACITY-1:0] prev_a;
  logic [CAPACITY-1:0] hit;

  key_t red_bound;
  logic red_hit;
  logic red_eq;

  always_comb begin
    prev_key[0] = '0;
    prev_ge[0]  = 1'b0;
    prev_a[0]   = 1'b0;
    for (int i = 1; i < CAPACITY; i++) begin
      prev_key[i] = cell_key[i-1];
      prev_ge[i]  = cell_ge[i-1];
      prev_a[i]   = cell_a[i-1];
    end
    for (int i = 0; i < CAPACITY; i++) begin
      cell_vld[i] = (CNT_W'(i) < count_r);
    end
    hit = cell_ge & ~prev_ge;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    osil_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .vld      (cell_vld[i]),
      .prev_key (prev_key[i]),
      .prev_a   (prev_a[i]),
      .key_r    (cell_key[i]),
      .ge_r     (cell_ge[i]),
      .a_r      (cell_a[i]),
      .eq_r     (cell_eq[i])
    );
  end

  osil_reduce u_reduce (
    .clk     (clk),
    .en      (red_en),
    .hit     (hit),
    .eq      (cell_eq),
    .keys    (cell_key),
    .bound   (red_bound),
    .any_hit (red_hit),
    .any_eq  (red_eq)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_word.valid) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP:  state_nxt = S_RED1;
      S_RED1: state_nxt = S_RED2;
      S_RED2: begin
        if (!out_valid_r || out_word.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    full       = (count_r == CNT_W'(CAPACITY));
    in_word.ready = (state_r == S_IDLE);
    accept     = in_word.valid && in_word.ready;
    red_en     = (state_r == S_RED1);
    out_load   = (state_r == S_RED2) && (!out_valid_r || out_word.ready);
    do_insert  = out_load && (mode_r == MODE_INSERT) && !red_eq && !full;
    ctl.cmp    = (state_r == S_CMP);
    ctl.shift  = do_insert;
    ctl.probe  = probe_r;
    count_nxt  = do_insert ? count_r + 1'b1 : count_r;

    if (mode_r == MODE_QUERY) begin
      status_nxt = ST_ANSWERED;
    end else if (red_eq) begin
      status_nxt = ST_DUPLICATE;
    end else if (full) begin
      status_nxt = ST_FULL;
    end else begin
      status_nxt = ST_INSERTED;
    end

    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_word.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      probe_r <= in_word.key;
      mode_r  <= in_word.mode;
    end
    if (out_load) begin
      status_r <= status_nxt;
      found_r  <= (mode_r == MODE_QUERY) && red_hit;
      bound_r  <= (mode_r == MODE_QUERY) ? red_bound : '0;
    end
  end

  assign out_word.valid     = out_valid_r;
  assign out_word.status    = status_r;
  assign out_word.found     = found_r;
  assign out_word.bound_key = bound_r;

endmodule
